// ===== src/tmbcr_pkg.sv =====
// Shared types and constants for the tile map box collision resolver.
// No dependencies; imported by tmbcr_push_step and the top level.
package tmbcr_pkg;

    localparam int POS_W      = 18;                 // position, 8 fraction bits
    localparam int DIM_W      = 16;                 // box width / height
    localparam int FRAC_W     = 8;
    localparam int IDX_W      = 6;                  // cell_row / cell_col fields
    localparam int CORNER_W   = POS_W + 1;          // pos + box dimension
    localparam int QUOT_W     = CORNER_W - FRAC_W;  // whole-pixel corner coordinate
    // Signed distance width: covers tile centres up to 256 tiles of 64 pixels.
    localparam int DIST_W     = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [DIM_W-1:0] BOX_DIM_RST = 16'd4096;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_RESOLVE = 1'b1
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_WIDTH  = 1'b0,
        CFG_BOX_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position carried from one push step to the next.
    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic             pushed;
    } push_state_t;

endpackage

// ===== src/tmbcr_push_step.sv =====
// One push-out step of a box against a single map tile (combinational).
// Depends on tmbcr_pkg.
module tmbcr_push_step import tmbcr_pkg::*; #(
    parameter int TILE_W = 16,
    parameter int TILE_H = 16,
    parameter int COL_W  = 6,
    parameter int ROW_W  = 6
) (
    input  logic              solid,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,
    input  push_state_t       state_i,
    output push_state_t       state_o
);

    localparam int TW     = TILE_W << FRAC_W;
    localparam int TH     = TILE_H << FRAC_W;
    localparam int HALF_X = TILE_W << (FRAC_W - 1);
    localparam int HALF_Y = TILE_H << (FRAC_W - 1);
    localparam int LIM_X  = 3 * HALF_X;   // 1.5 tiles
    localparam int LIM_Y  = 3 * HALF_Y;

    logic signed [DIST_W-1:0] agent_x, centre_x, dist_x, abs_x, depth_x, move_x;
    logic signed [DIST_W-1:0] agent_y, centre_y, dist_y, abs_y, depth_y, move_y;
    logic                     hit;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [DIST_W-1:0] v);
        if (v[DIST_W-1]) begin
            return '0;
        end else if (v > $signed(DIST_W'(POS_MAX))) begin
            return POS_MAX;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

    always_comb begin
        agent_x  = DIST_W'(state_i.px) + DIST_W'(TW);
        centre_x = DIST_W'(col) * DIST_W'(TW) + DIST_W'(HALF_X);
        dist_x   = agent_x - centre_x;
        abs_x    = dist_x[DIST_W-1] ? -dist_x : dist_x;
        depth_x  = DIST_W'(LIM_X) - abs_x;
        move_x   = dist_x[DIST_W-1] ? DIST_W'(state_i.px) - depth_x
                                    : DIST_W'(state_i.px) + depth_x;

        agent_y  = DIST_W'(state_i.py) + DIST_W'(TH);
        centre_y = DIST_W'(row) * DIST_W'(TH) + DIST_W'(HALF_Y);
        dist_y   = agent_y - centre_y;
        abs_y    = dist_y[DIST_W-1] ? -dist_y : dist_y;
        depth_y  = DIST_W'(LIM_Y) - abs_y;
        move_y   = dist_y[DIST_W-1] ? DIST_W'(state_i.py) - depth_y
                                    : DIST_W'(state_i.py) + depth_y;

        // both depths strictly positive
        hit = solid && !depth_x[DIST_W-1] && (depth_x != '0)
                    && !depth_y[DIST_W-1] && (depth_y != '0);

        state_o = state_i;
        if (hit) begin
            state_o.pushed = 1'b1;
            if (depth_x < depth_y) begin
                state_o.px = clamp_pos(move_x);
            end else begin
                state_o.py = clamp_pos(move_y);   // ties go to y
            end
        end
    end

endmodule

// ===== src/tile_map_box_collision_resolve_top.sv =====
// Top level of the tile map box collision resolver: map store, corner lookup,
// four-stage push pipeline and output register. Depends on tmbcr_pkg, tmbcr_push_step.
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ------------------------------------------
//  s_        in   s_tvalid / s_tready     s_tuser: op; s_tdata: row, col, solid, x, y
//  m_        out  m_tvalid / m_tready     m_tdata: new_x, new_y, was_pushed
//  cfg_      in   cfg_wr_en (no stall)    cfg_addr: register index, cfg_wr_data
//
//  One transfer per cycle sustained in both directions; the pipeline is fully stalled
//  only by the output register. A resolve result passes through the input register,
//  the map row read into stage 0 and one push step per pipeline stage to the output.
//  Map write items take effect in the cycle after acceptance and produce no transfer.
//  Reset clears one valid bit per map row at once; an unwritten row reads as open,
//  so no clearing pass is needed. Empty stages are filled while the output stalls.
module tile_map_box_collision_resolve_top import tmbcr_pkg::*; #(
    parameter int TILE_W   = 16,
    parameter int TILE_H   = 16,
    parameter int MAP_COLS = 64,
    parameter int MAP_ROWS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] cell_row, [11:6] cell_col, [12] cell_solid, [30:13] pos_x, [48:31] pos_y
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] op
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [17:0] new_x, [35:18] new_y, [36] was_pushed
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wr_data
);

    localparam int COL_W  = $clog2(MAP_COLS);
    localparam int ROW_W  = $clog2(MAP_ROWS);
    localparam int RCP_W  = QUOT_W + 2;
    localparam int PROD_W = QUOT_W + RCP_W;
    // Exact divide by tile size via reciprocal multiply for QUOT_W-bit dividends.
    localparam int SH_X   = QUOT_W + $clog2(TILE_W);
    localparam int SH_Y   = QUOT_W + $clog2(TILE_H);
    localparam int RCP_X  = ((1 << SH_X) + TILE_W - 1) / TILE_W;
    localparam int RCP_Y  = ((1 << SH_Y) + TILE_H - 1) / TILE_H;

    function automatic logic [QUOT_W-1:0] tile_index(input logic [QUOT_W-1:0] v,
                                                     input logic [RCP_W-1:0]  m,
                                                     input int                sh);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(m);
        return QUOT_W'(prod >> sh);
    endfunction

    // config registers
    logic [DIM_W-1:0]    box_w_reg, box_h_reg;

    // input register (P1)
    logic                p1_vld_reg;
    op_t                 p1_op_reg;
    logic [IDX_W-1:0]    p1_row_reg, p1_col_reg;
    logic                p1_solid_reg;
    logic [POS_W-1:0]    p1_x_reg, p1_y_reg;
    logic                p1_rdy, p1_fwd;

    // corner lookup
    logic [CORNER_W-1:0] corner_r, corner_b;
    logic [QUOT_W-1:0]   q_l, q_r, q_t, q_b;
    logic                l_ok, r_ok, t_ok, b_ok;

    // map store: one row of MAP_COLS cells per entry, plus row valid bits
    logic [MAP_COLS-1:0] tile_mem [MAP_ROWS];
    logic [MAP_ROWS-1:0] row_vld_reg;
    logic [MAP_COLS-1:0] wr_row_init;
    logic [ROW_W-1:0]    wr_row, rd_top, rd_bot;
    logic [COL_W-1:0]    wr_col;
    logic                mem_we;
    logic [MAP_COLS-1:0] top_row_reg, bot_row_reg;
    logic                top_rv_reg, bot_rv_reg;
    logic [3:0]          ok_reg;

    // push pipeline: stage k applies corner k (tl, tr, bl, br); index 4 = output
    logic                vld_reg   [5];
    push_state_t         st_reg    [5];
    push_state_t         step_out  [4];
    logic                rdy       [5];
    logic [COL_W-1:0]    col_l_reg [4];
    logic [COL_W-1:0]    col_r_reg [4];
    logic [ROW_W-1:0]    row_t_reg [4];
    logic [ROW_W-1:0]    row_b_reg [4];
    logic [3:0]          solid_reg [1:3];
    logic [3:0]          solid_w   [4];

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_w_reg <= BOX_DIM_RST;
            box_h_reg <= BOX_DIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_BOX_WIDTH:  box_w_reg <= cfg_wr_data;
                CFG_BOX_HEIGHT: box_h_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // A stage advances when empty or when the one after it advances.
    always_comb begin
        rdy[4] = !vld_reg[4] || m_tready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        // write items retire from P1 without entering the push pipeline
        p1_rdy = !p1_vld_reg || (p1_op_reg == OP_WRITE) || rdy[0];
        p1_fwd = p1_vld_reg && (p1_op_reg == OP_RESOLVE);
    end

    assign s_tready = p1_rdy;

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (p1_rdy) begin
            p1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_rdy && s_tvalid) begin
            p1_op_reg    <= op_t'(s_tuser);
            p1_row_reg   <= s_tdata[5:0];
            p1_col_reg   <= s_tdata[11:6];
            p1_solid_reg <= s_tdata[12];
            p1_x_reg     <= s_tdata[30:13];
            p1_y_reg     <= s_tdata[48:31];
        end
    end

    // ---------------- corner tiles, map write ----------------
    always_comb begin
        corner_r = CORNER_W'(p1_x_reg) + CORNER_W'(box_w_reg);
        corner_b = CORNER_W'(p1_y_reg) + CORNER_W'(box_h_reg);
        q_l  = tile_index(QUOT_W'(p1_x_reg[POS_W-1:FRAC_W]), RCP_W'(RCP_X), SH_X);
        q_r  = tile_index(corner_r[CORNER_W-1:FRAC_W], RCP_W'(RCP_X), SH_X);
        q_t  = tile_index(QUOT_W'(p1_y_reg[POS_W-1:FRAC_W]), RCP_W'(RCP_Y), SH_Y);
        q_b  = tile_index(corner_b[CORNER_W-1:FRAC_W], RCP_W'(RCP_Y), SH_Y);
        // corners off the map count as open
        l_ok = q_l < QUOT_W'(MAP_COLS);
        r_ok = q_r < QUOT_W'(MAP_COLS);
        t_ok = q_t < QUOT_W'(MAP_ROWS);
        b_ok = q_b < QUOT_W'(MAP_ROWS);
        rd_top = ROW_W'(q_t);
        rd_bot = ROW_W'(q_b);

        // writes outside the map are dropped
        wr_row = ROW_W'(p1_row_reg);
        wr_col = COL_W'(p1_col_reg);
        mem_we = p1_vld_reg && (p1_op_reg == OP_WRITE)
                 && (9'(p1_row_reg) < 9'(MAP_ROWS))
                 && (9'(p1_col_reg) < 9'(MAP_COLS));
        wr_row_init         = '0;
        wr_row_init[wr_col] = p1_solid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (mem_we) begin
            row_vld_reg[wr_row] <= 1'b1;
        end
    end

    // First write to a row lays down the whole row; later writes touch one cell.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            if (row_vld_reg[wr_row]) begin
                tile_mem[wr_row][wr_col] <= p1_solid_reg;
            end else begin
                tile_mem[wr_row] <= wr_row_init;
            end
        end
        if (rdy[0]) begin
            top_row_reg <= tile_mem[rd_top];
            bot_row_reg <= tile_mem[rd_bot];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            top_rv_reg   <= row_vld_reg[rd_top];
            bot_rv_reg   <= row_vld_reg[rd_bot];
            ok_reg       <= {r_ok && b_ok, l_ok && b_ok, r_ok && t_ok, l_ok && t_ok};
        end
    end

    // ---------------- push pipeline ----------------
    // All four corners are classified from the original position in stage 0.
    always_comb begin
        solid_w[0] = ok_reg & {bot_rv_reg && bot_row_reg[col_r_reg[0]],
                               bot_rv_reg && bot_row_reg[col_l_reg[0]],
                               top_rv_reg && top_row_reg[col_r_reg[0]],
                               top_rv_reg && top_row_reg[col_l_reg[0]]};
        for (int k = 1; k < 4; k++) begin
            solid_w[k] = solid_reg[k];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_step
        tmbcr_push_step #(
            .TILE_W (TILE_W),
            .TILE_H (TILE_H),
            .COL_W  (COL_W),
            .ROW_W  (ROW_W)
        ) u_step (
            .solid   (solid_w[k][k]),
            .col     ((k % 2 == 0) ? col_l_reg[k] : col_r_reg[k]),
            .row     ((k < 2) ? row_t_reg[k] : row_b_reg[k]),
            .state_i (st_reg[k]),
            .state_o (step_out[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= p1_fwd;
            end
            for (int k = 0; k < 4; k++) begin
                if (rdy[k+1]) begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        // stage 0 loads from the input register
        if (rdy[0]) begin
            st_reg[0]    <= '{px: p1_x_reg, py: p1_y_reg, pushed: 1'b0};
            col_l_reg[0] <= COL_W'(q_l);
            col_r_reg[0] <= COL_W'(q_r);
            row_t_reg[0] <= rd_top;
            row_b_reg[0] <= rd_bot;
        end
        for (int k = 0; k < 4; k++) begin
            if (rdy[k+1]) begin
                st_reg[k+1] <= step_out[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (rdy[k+1]) begin
                solid_reg[k+1] <= solid_w[k];
                col_l_reg[k+1] <= col_l_reg[k];
                col_r_reg[k+1] <= col_r_reg[k];
                row_t_reg[k+1] <= row_t_reg[k];
                row_b_reg[k+1] <= row_b_reg[k];
            end
        end
    end

    // ---------------- output ----------------
    assign m_tvalid = vld_reg[4];
    assign m_tdata  = {3'b000, st_reg[4].pushed, st_reg[4].py, st_reg[4].px};

    // ---------------- assertions ----------------
    // Input can only be held off by a stalled, full output register.
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // Map rows once written stay written until reset.
    a_row_vld_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(row_vld_reg) >= $past($countones(row_vld_reg)))
        else $error("map row valid bit lost");

    // A result only appears from the last push stage.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vld_reg[3]))
        else $error("result without a last-stage item");

    for (genvar k = 0; k < 4; k++) begin : g_chk
        // one push step moves along one axis only
        a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
            vld_reg[k] |-> !((step_out[k].px != st_reg[k].px) &&
                             (step_out[k].py != st_reg[k].py)))
            else $error("push step moved both axes");

        // any movement is flagged as a push
        a_move_flag: assert property (@(posedge aclk) disable iff (!aresetn)
            (vld_reg[k] && ((step_out[k].px != st_reg[k].px) ||
                            (step_out[k].py != st_reg[k].py))) |-> step_out[k].pushed)
            else $error("position moved without push flag");
    end

endmodule
